// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every clock edge outside reset
`define GRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every clock edge, reset included
`define GRC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/grc_pkg.sv =====
package grc_pkg;

    localparam int MAP_SIDE   = 64;
    localparam int MAX_STEPS  = 20;
    localparam int MAP_BITS   = $clog2(MAP_SIDE);
    localparam int MAP_CELLS  = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W     = $clog2(MAP_CELLS);
    localparam int LIM_W      = $clog2(MAP_SIDE + 1);
    localparam int STEP_W     = $clog2(MAX_STEPS + 1);
    localparam int TILE_SHIFT = 14;
    localparam int POS_W      = 40;
    localparam int MUL_A_W    = 25;
    localparam int MUL_B_W    = 32;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int SQ_W       = 48;
    localparam int ROOT_W     = SQ_W / 2;
    localparam int REM_W      = ROOT_W + 3;
    localparam int ITER_W     = $clog2(ROOT_W);
    localparam int CFG_W      = 7;

    localparam logic [20:0] DIST_MAX = 21'h1FFFFF;
    localparam logic signed [POS_W-1:0] POS_MAX = POS_W'(64'sd8388607);
    localparam logic signed [POS_W-1:0] POS_MIN = POS_W'(-64'sd8388608);
    localparam logic signed [POS_W-1:0] TILE_Q8 = POS_W'(64'sd16384);

    localparam logic [15:0] ANG_0   = 16'd0;
    localparam logic [15:0] ANG_90  = 16'd16384;
    localparam logic [15:0] ANG_180 = 16'd32768;
    localparam logic [15:0] ANG_270 = 16'd49152;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_H_MUL,
        S_H_START,
        S_V_MUL,
        S_V_START,
        S_WALK_ADDR,
        S_WALK_TEST,
        S_DX,
        S_DY,
        S_SQ_LOAD,
        S_SQRT,
        S_SQ_DONE,
        S_SELECT
    } grc_state_t;

    function automatic logic [LIM_W-1:0] used_size(input logic [CFG_W-1:0] r);
        logic [LIM_W-1:0] v;
        begin
            if (r == '0)
                v = LIM_W'(1);
            else if (int'(r) > MAP_SIDE)
                v = LIM_W'(MAP_SIDE);
            else
                v = LIM_W'(r);
            return v;
        end
    endfunction

    function automatic logic [MAP_BITS-1:0] cell_of(input logic signed [POS_W-1:0] p,
                                                    input logic [LIM_W-1:0] lim);
        logic [POS_W-TILE_SHIFT-1:0] c;
        logic [MAP_BITS-1:0]         v;
        begin
            c = p[POS_W-1:TILE_SHIFT];
            if (p[POS_W-1])
                v = '0;
            else if (c >= (POS_W-TILE_SHIFT)'(lim))
                v = MAP_BITS'(lim - LIM_W'(1));
            else
                v = c[MAP_BITS-1:0];
            return v;
        end
    endfunction

    function automatic logic signed [23:0] sat_pos(input logic signed [POS_W-1:0] v);
        logic signed [23:0] r;
        begin
            if (v > POS_MAX)
                r = 24'sh7FFFFF;
            else if (v < POS_MIN)
                r = 24'sh800000;
            else
                r = v[23:0];
            return r;
        end
    endfunction

endpackage

// ===== hdl/grc_stream_if.sv =====
interface grc_in_if;
    import grc_pkg::*;

    logic        valid;
    logic        ready;
    logic        op;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic        cell_wall;
    logic [19:0] player_x;
    logic [19:0] player_y;
    logic [15:0] ray_angle;
    logic signed [31:0] ray_tangent;
    logic signed [31:0] ray_cotangent;

    modport source (
        output valid, op, cell_x, cell_y, cell_wall, player_x, player_y,
               ray_angle, ray_tangent, ray_cotangent,
        input  ready
    );

    modport sink (
        input  valid, op, cell_x, cell_y, cell_wall, player_x, player_y,
               ray_angle, ray_tangent, ray_cotangent,
        output ready
    );
endinterface

interface grc_out_if;
    import grc_pkg::*;

    logic        valid;
    logic        ready;
    logic        hit_found;
    logic        hit_side;
    logic signed [23:0] hit_x;
    logic signed [23:0] hit_y;
    logic [20:0] hit_distance;

    modport source (
        output valid, hit_found, hit_side, hit_x, hit_y, hit_distance,
        input  ready
    );

    modport sink (
        input  valid, hit_found, hit_side, hit_x, hit_y, hit_distance,
        output ready
    );
endinterface

// ===== hdl/grid_ray_caster_core.sv =====
// Grid ray caster: holds a 64 x 64 one-bit wall map of 64-unit tiles and casts one ray per
// op 1 beat, stepping row crossings and then column crossings (at most 20 probes each) and
// returning the nearer hit with its side, point and Euclidean distance; an op 0 beat writes
// one map cell and returns an all-zero result. A cast runs a setup per direction (multiply,
// then start), then map probes through a registered map read, then for each hit two squarings
// and a 24-step bit-pair square root, and finally picks the result, all on the single shared
// multiplier and root unit. After reset the map is cleared one cell a cycle, during which
// no beat is accepted; configuration writes are taken at any time.
`include "assert_macros.svh"

module grid_ray_caster_core
    import grc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    grc_in_if.sink            req,
    grc_out_if.source         rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    grc_state_t state_reg, state_next;

    logic [CFG_W-1:0] map_w_reg, map_h_reg;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [ITER_W-1:0] it_reg, it_next;
    logic rsp_valid_reg, rsp_valid_next;

    logic [19:0] px_reg, py_reg;
    logic [15:0] ang_reg;
    logic signed [31:0] tn_reg, ct_reg;
    logic is_wr_reg, is_wr_next;
    logic cast_v_reg, cast_v_next;
    logic signed [POS_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [POS_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next, prod_sh;
    logic [SQ_W-1:0] acc_reg, acc_next, rad_reg, rad_next;
    logic [REM_W-1:0] rem_reg, rem_next, rem_sh, trial;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic signed [23:0] hx_reg, hx_next, hy_reg, hy_next;
    logic h_hit_reg, h_hit_next, v_hit_reg, v_hit_next;
    logic signed [23:0] h_x_reg, h_x_next, h_y_reg, h_y_next;
    logic signed [23:0] v_x_reg, v_x_next, v_y_reg, v_y_next;
    logic [20:0] h_d_reg, h_d_next, v_d_reg, v_d_next;
    logic [20:0] dist_sat;
    logic o_found_reg, o_found_next, o_side_reg, o_side_next;
    logic signed [23:0] o_x_reg, o_x_next, o_y_reg, o_y_next;
    logic [20:0] o_d_reg, o_d_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [15:0] a_off;
    logic signed [MUL_A_W-1:0] dx, dy;
    logic signed [POS_W-1:0] px_ext, py_ext, base_x, base_y, tq, cq;
    logic up_y, left_x, skip_h, skip_v, slot_free, accept;

    logic wall_mem [MAP_CELLS];
    logic mem_we, mem_wd, mem_rd_reg;
    logic [ADDR_W-1:0] mem_wa, mem_ra;
    logic [LIM_W-1:0] lim_w, lim_h;

    // configuration port
    assign pready = 1'b1;
    always_comb
    begin
        if (paddr[2] == REG_MAP_HEIGHT)
            prdata = {25'd0, map_h_reg};
        else
            prdata = {25'd0, map_w_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_w_reg <= CFG_W'(64);
            map_h_reg <= CFG_W'(64);
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_MAP_HEIGHT)
                map_h_reg <= pwdata[CFG_W-1:0];
            else
                map_w_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign lim_w = used_size(map_w_reg);
    assign lim_h = used_size(map_h_reg);

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign slot_free = !rsp_valid_reg || rsp.ready;

    assign up_y   = (ang_reg < ANG_180);
    assign left_x = (ang_reg > ANG_90) && (ang_reg < ANG_270);
    assign skip_h = (ang_reg == ANG_0) || (ang_reg == ANG_180);
    assign skip_v = (ang_reg == ANG_90) || (ang_reg == ANG_270);

    assign px_ext = $signed({{(POS_W-20){1'b0}}, px_reg});
    assign py_ext = $signed({{(POS_W-20){1'b0}}, py_reg});
    assign base_x = $signed({{(POS_W-20){1'b0}}, px_reg[19:TILE_SHIFT], {TILE_SHIFT{1'b0}}});
    assign base_y = $signed({{(POS_W-20){1'b0}}, py_reg[19:TILE_SHIFT], {TILE_SHIFT{1'b0}}});
    assign tq     = POS_W'(tn_reg >>> 2);
    assign cq     = POS_W'(ct_reg >>> 2);
    assign prod_sh = prod_reg >>> 16;
    assign dx = $signed({hx_reg[23], hx_reg}) - $signed({5'd0, px_reg});
    assign dy = $signed({hy_reg[23], hy_reg}) - $signed({5'd0, py_reg});

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[SQ_W-1:SQ_W-2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign dist_sat = (|root_reg[ROOT_W-1:21]) ? DIST_MAX : root_reg[20:0];

    // wall map
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = clr_reg;
        mem_wd = 1'b0;
        if (state_reg == S_CLEAR)
            mem_we = 1'b1;
        else if (accept && req.op == OP_WRITE && int'(req.cell_x) < MAP_SIDE
                 && int'(req.cell_y) < MAP_SIDE)
        begin
            mem_we = 1'b1;
            mem_wa = ADDR_W'(int'(req.cell_y) * MAP_SIDE + int'(req.cell_x));
            mem_wd = req.cell_wall;
        end
    end

    assign mem_ra = ADDR_W'(int'(cell_of(y_reg, lim_h)) * MAP_SIDE + int'(cell_of(x_reg, lim_w)));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            wall_mem[mem_wa] <= mem_wd;
        mem_rd_reg <= wall_mem[mem_ra];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:     if (clr_reg == ADDR_W'(MAP_CELLS - 1)) state_next = S_IDLE;
            S_IDLE:
            begin
                if (accept)
                    state_next = (req.op == OP_WRITE) ? S_SELECT : S_H_MUL;
            end
            S_H_MUL:     state_next = skip_h ? S_V_MUL : S_H_START;
            S_H_START:   state_next = S_WALK_ADDR;
            S_V_MUL:     state_next = skip_v ? S_SELECT : S_V_START;
            S_V_START:   state_next = S_WALK_ADDR;
            S_WALK_ADDR: state_next = S_WALK_TEST;
            S_WALK_TEST:
            begin
                if (mem_rd_reg)
                    state_next = S_DX;
                else if (step_reg == STEP_W'(MAX_STEPS - 1))
                    state_next = cast_v_reg ? S_SELECT : S_V_MUL;
                else
                    state_next = S_WALK_ADDR;
            end
            S_DX:        state_next = S_DY;
            S_DY:        state_next = S_SQ_LOAD;
            S_SQ_LOAD:   state_next = S_SQRT;
            S_SQRT:      if (it_reg == ITER_W'(ROOT_W - 1)) state_next = S_SQ_DONE;
            S_SQ_DONE:   state_next = cast_v_reg ? S_SELECT : S_V_MUL;
            S_SELECT:    if (slot_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        clr_next = clr_reg;
        step_next = step_reg;
        it_next = it_reg;
        rsp_valid_next = rsp_valid_reg;
        is_wr_next = is_wr_reg;
        cast_v_next = cast_v_reg;
        x_next = x_reg;
        y_next = y_reg;
        sx_next = sx_reg;
        sy_next = sy_reg;
        prod_next = prod_reg;
        acc_next = acc_reg;
        rad_next = rad_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        hx_next = hx_reg;
        hy_next = hy_reg;
        h_hit_next = h_hit_reg;
        v_hit_next = v_hit_reg;
        h_x_next = h_x_reg;
        h_y_next = h_y_reg;
        v_x_next = v_x_reg;
        v_y_next = v_y_reg;
        h_d_next = h_d_reg;
        v_d_next = v_d_reg;
        o_found_next = o_found_reg;
        o_side_next = o_side_reg;
        o_x_next = o_x_reg;
        o_y_next = o_y_reg;
        o_d_next = o_d_reg;
        mul_a = '0;
        mul_b = '0;
        a_off = '0;

        if (rsp_valid_reg && rsp.ready)
            rsp_valid_next = 1'b0;

        case (state_reg)
            S_CLEAR:
                clr_next = clr_reg + ADDR_W'(1);
            S_IDLE:
            begin
                is_wr_next = (req.op == OP_WRITE);
                h_hit_next = 1'b0;
                v_hit_next = 1'b0;
            end
            S_H_MUL:
            begin
                a_off = $signed({2'b00, py_reg[TILE_SHIFT-1:0]})
                        + (up_y ? 16'sd1 : -16'sd16384);
                mul_a = MUL_A_W'(a_off);
                mul_b = ct_reg;
                prod_next = mul_a * mul_b;
            end
            S_H_START:
            begin
                cast_v_next = 1'b0;
                step_next = '0;
                x_next = px_ext + prod_sh[POS_W-1:0];
                y_next = up_y ? base_y - POS_W'(1) : base_y + TILE_Q8;
                sx_next = up_y ? cq : -cq;
                sy_next = up_y ? -TILE_Q8 : TILE_Q8;
            end
            S_V_MUL:
            begin
                a_off = $signed({2'b00, px_reg[TILE_SHIFT-1:0]})
                        + (left_x ? 16'sd1 : -16'sd16384);
                mul_a = MUL_A_W'(a_off);
                mul_b = tn_reg;
                prod_next = mul_a * mul_b;
            end
            S_V_START:
            begin
                cast_v_next = 1'b1;
                step_next = '0;
                x_next = left_x ? base_x - POS_W'(1) : base_x + TILE_Q8;
                y_next = py_ext + prod_sh[POS_W-1:0];
                sx_next = left_x ? -TILE_Q8 : TILE_Q8;
                sy_next = left_x ? tq : -tq;
            end
            S_WALK_TEST:
            begin
                if (mem_rd_reg)
                begin
                    hx_next = sat_pos(x_reg);
                    hy_next = sat_pos(y_reg);
                end
                else
                begin
                    x_next = x_reg + sx_reg;
                    y_next = y_reg + sy_reg;
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_DX:
            begin
                mul_a = dx;
                mul_b = MUL_B_W'(dx);
                prod_next = mul_a * mul_b;
            end
            S_DY:
            begin
                acc_next = prod_reg[SQ_W-1:0];
                mul_a = dy;
                mul_b = MUL_B_W'(dy);
                prod_next = mul_a * mul_b;
            end
            S_SQ_LOAD:
            begin
                rad_next = acc_reg + prod_reg[SQ_W-1:0];
                rem_next = '0;
                root_next = '0;
                it_next = '0;
            end
            S_SQRT:
            begin
                rad_next = {rad_reg[SQ_W-3:0], 2'b00};
                it_next = it_reg + ITER_W'(1);
                if (rem_sh >= trial)
                begin
                    rem_next = rem_sh - trial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            S_SQ_DONE:
            begin
                if (cast_v_reg)
                begin
                    v_hit_next = 1'b1;
                    v_x_next = hx_reg;
                    v_y_next = hy_reg;
                    v_d_next = dist_sat;
                end
                else
                begin
                    h_hit_next = 1'b1;
                    h_x_next = hx_reg;
                    h_y_next = hy_reg;
                    h_d_next = dist_sat;
                end
            end
            S_SELECT:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    o_found_next = 1'b0;
                    o_side_next = 1'b0;
                    o_x_next = '0;
                    o_y_next = '0;
                    o_d_next = '0;
                    if (!is_wr_reg)
                    begin
                        if (!h_hit_reg && !v_hit_reg)
                            o_d_next = DIST_MAX;
                        else if (h_hit_reg && (!v_hit_reg || h_d_reg < v_d_reg))
                        begin
                            o_found_next = 1'b1;
                            o_x_next = h_x_reg;
                            o_y_next = h_y_reg;
                            o_d_next = h_d_reg;
                        end
                        else
                        begin
                            o_found_next = 1'b1;
                            o_side_next = 1'b1;
                            o_x_next = v_x_reg;
                            o_y_next = v_y_reg;
                            o_d_next = v_d_reg;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            step_reg <= '0;
            it_reg <= '0;
            rsp_valid_reg <= 1'b0;
            is_wr_reg <= 1'b0;
            cast_v_reg <= 1'b0;
            h_hit_reg <= 1'b0;
            v_hit_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            step_reg <= step_next;
            it_reg <= it_next;
            rsp_valid_reg <= rsp_valid_next;
            is_wr_reg <= is_wr_next;
            cast_v_reg <= cast_v_next;
            h_hit_reg <= h_hit_next;
            v_hit_reg <= v_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= req.player_x;
            py_reg <= req.player_y;
            ang_reg <= req.ray_angle;
            tn_reg <= req.ray_tangent;
            ct_reg <= req.ray_cotangent;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        sx_reg <= sx_next;
        sy_reg <= sy_next;
        prod_reg <= prod_next;
        acc_reg <= acc_next;
        rad_reg <= rad_next;
        rem_reg <= rem_next;
        root_reg <= root_next;
        hx_reg <= hx_next;
        hy_reg <= hy_next;
        h_x_reg <= h_x_next;
        h_y_reg <= h_y_next;
        v_x_reg <= v_x_next;
        v_y_reg <= v_y_next;
        h_d_reg <= h_d_next;
        v_d_reg <= v_d_next;
        o_found_reg <= o_found_next;
        o_side_reg <= o_side_next;
        o_x_reg <= o_x_next;
        o_y_reg <= o_y_next;
        o_d_reg <= o_d_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.hit_found    = o_found_reg;
    assign rsp.hit_side     = o_side_reg;
    assign rsp.hit_x        = o_x_reg;
    assign rsp.hit_y        = o_y_reg;
    assign rsp.hit_distance = o_d_reg;

    `GRC_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> state_reg == S_CLEAR && !rsp_valid_reg, "reset must restart the map clear")
    `GRC_ASSERT(a_write_beat, req.valid && req.ready && req.op == OP_WRITE |=> state_reg == S_SELECT && is_wr_reg, "map write must go straight to the result")
    `GRC_ASSERT(a_step_bound, state_reg == S_WALK_TEST |-> step_reg < STEP_W'(MAX_STEPS), "probe count overran")
    `GRC_ASSERT(a_nohit_zero, rsp.valid && !rsp.hit_found |-> rsp.hit_x == 0 && rsp.hit_y == 0 && !rsp.hit_side, "no-hit beat carries a hit point")

endmodule
